### rtl/rrtq_pkg.sv
// Package for the round-robin task queue: event codes, fixed field widths
// and the result beat layout. No dependencies.
package rrtq_pkg;

  localparam int unsigned ModeWidth   = 3;
  localparam int unsigned TaskIdWidth = 16;
  localparam int unsigned OutIdWidth  = 16;
  localparam int unsigned PidWidth    = 22;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 64;

  localparam logic [ModeWidth-1:0] ModeCreate = 3'd0;
  localparam logic [ModeWidth-1:0] ModeKill   = 3'd1;
  localparam logic [ModeWidth-1:0] ModeExit   = 3'd2;
  localparam logic [ModeWidth-1:0] ModeStop   = 3'd3;
  localparam logic [ModeWidth-1:0] ModeTick   = 3'd4;

  // Laid out so that the packed struct is the output beat, lowest field last.
  typedef struct packed {
    logic                  queue_full;
    logic                  queue_empty;
    logic                  activate;
    logic [PidWidth-1:0]   activate_pid;
    logic                  found;
    logic [PidWidth-1:0]   target_pid;
    logic [OutIdWidth-1:0] assigned_id;
  } rrtq_res_t;

endpackage

### rtl/rrtq_mem.sv
// Task table storage: one write port and one read port with registered
// read data. Depends on nothing.
module rrtq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 38
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/rrtq_seq.sv
// Event sequencer: walks, compacts and rotates the task table in rrtq_mem
// one entry per cycle. Depends on rrtq_pkg.
module rrtq_seq #(
  parameter int unsigned Depth   = 16,
  parameter int unsigned IdWidth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rrtq_pkg::ModeWidth-1:0]       in_mode_i,
  input  logic [rrtq_pkg::TaskIdWidth-1:0]     in_task_id_i,
  input  logic [rrtq_pkg::PidWidth-1:0]        in_pid_i,
  output logic                                 wr_en_o,
  output logic [$clog2(Depth)-1:0]             wr_addr_o,
  output logic [IdWidth+rrtq_pkg::PidWidth-1:0] wr_data_o,
  output logic                                 rd_en_o,
  output logic [$clog2(Depth)-1:0]             rd_addr_o,
  input  logic [IdWidth+rrtq_pkg::PidWidth-1:0] rd_data_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output rrtq_pkg::rrtq_res_t                  res_o
);
  import rrtq_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (IdWidth > TaskIdWidth) ? IdWidth : TaskIdWidth;

  typedef enum logic [2:0] {
    StIdle, StStart, StScan, StMove, StHead, StAct, StActChk, StDone
  } state_e;

  state_e                 state_q, state_d;
  logic [ModeWidth-1:0]   mode_q, mode_d;
  logic [TaskIdWidth-1:0] tid_q, tid_d;
  logic [PidWidth-1:0]    pid_q, pid_d;
  logic [IdxW-1:0]        head_q, head_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdWidth-1:0]     idc_q, idc_d;
  logic [CntW-1:0]        pos_q, pos_d;
  logic [IdxW-1:0]        slot_q, slot_d;
  rrtq_res_t              res_q, res_d;

  logic [IdWidth-1:0]  rd_id;
  logic [PidWidth-1:0] rd_pid;
  logic [IdxW-1:0]     slot_nx, slot_nx2, tail;
  logic [CntW:0]       tail_sum;
  logic                hit;

  function automatic logic [IdxW-1:0] slot_inc(input logic [IdxW-1:0] s);
    slot_inc = (s == IdxW'(Depth - 1)) ? '0 : s + IdxW'(1);
  endfunction

  assign rd_id    = rd_data_i[IdWidth+PidWidth-1:PidWidth];
  assign rd_pid   = rd_data_i[PidWidth-1:0];
  assign slot_nx  = slot_inc(slot_q);
  assign slot_nx2 = slot_inc(slot_nx);
  assign tail_sum = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail     = (tail_sum >= (CntW+1)'(Depth)) ? IdxW'(tail_sum - (CntW+1)'(Depth))
                                                   : IdxW'(tail_sum);
  assign hit      = (mode_q == ModeKill) ? (CmpW'(rd_id) == CmpW'(tid_q))
                                         : (rd_pid == pid_q);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    tid_d   = tid_q;
    pid_d   = pid_q;
    head_d  = head_q;
    count_d = count_q;
    idc_d   = idc_q;
    pos_d   = pos_q;
    slot_d  = slot_q;
    res_d   = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = slot_q;
    wr_en_o   = 1'b0;
    wr_addr_o = slot_q;
    wr_data_o = rd_data_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          tid_d   = in_task_id_i;
          pid_d   = in_pid_i;
          res_d   = '0;
          state_d = StStart;
        end
      end
      StStart: begin
        pos_d  = '0;
        slot_d = head_q;
        unique case (mode_q)
          ModeCreate: begin
            if (count_q == CntW'(Depth)) begin
              res_d.queue_full = 1'b1;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = tail;
              wr_data_o = {idc_q, pid_q};
              res_d.assigned_id = OutIdWidth'(idc_q);
              count_d = count_q + CntW'(1);
              idc_d   = (&idc_q) ? IdWidth'(1) : idc_q + IdWidth'(1);
            end
            state_d = StDone;
          end
          ModeKill, ModeExit: begin
            if (count_q == '0) begin
              state_d = (mode_q == ModeKill) ? StDone : StAct;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = head_q;
              state_d   = StScan;
            end
          end
          ModeStop, ModeTick: begin
            if (count_q == '0) begin
              state_d = (mode_q == ModeStop) ? StAct : StDone;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = head_q;
              state_d   = StHead;
            end
          end
          default: state_d = StDone;
        endcase
      end
      StScan: begin
        if (hit) begin
          res_d.found       = 1'b1;
          res_d.assigned_id = OutIdWidth'(rd_id);
          if (mode_q == ModeKill) begin
            res_d.target_pid = rd_pid;
            state_d = StDone;
          end else begin
            count_d = count_q - CntW'(1);
            if (pos_q < count_q - CntW'(1)) begin
              rd_en_o   = 1'b1;
              rd_addr_o = slot_nx;
              state_d   = StMove;
            end else begin
              state_d = StAct;
            end
          end
        end else begin
          pos_d  = pos_q + CntW'(1);
          slot_d = slot_nx;
          if (pos_q + CntW'(1) < count_q) begin
            rd_en_o   = 1'b1;
            rd_addr_o = slot_nx;
          end else begin
            state_d = (mode_q == ModeKill) ? StDone : StAct;
          end
        end
      end
      StMove: begin
        wr_en_o   = 1'b1;
        wr_addr_o = slot_q;
        wr_data_o = rd_data_i;
        pos_d  = pos_q + CntW'(1);
        slot_d = slot_nx;
        if (pos_q + CntW'(1) < count_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = slot_nx2;
        end else begin
          state_d = StAct;
        end
      end
      StHead: begin
        if (mode_q == ModeStop) begin
          if (rd_pid == pid_q) begin
            wr_en_o   = 1'b1;
            wr_addr_o = tail;
            wr_data_o = rd_data_i;
            head_d    = slot_inc(head_q);
            res_d.found = 1'b1;
          end
          state_d = StAct;
        end else begin
          res_d.assigned_id = OutIdWidth'(rd_id);
          res_d.target_pid  = rd_pid;
          state_d = StDone;
        end
      end
      StAct: begin
        if (count_q == '0) begin
          state_d = StDone;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = head_q;
          state_d   = StActChk;
        end
      end
      StActChk: begin
        res_d.activate     = 1'b1;
        res_d.activate_pid = rd_pid;
        state_d = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
      idc_q   <= IdWidth'(1);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idc_q   <= idc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    tid_q  <= tid_d;
    pid_q  <= pid_d;
    pos_q  <= pos_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);

  always_comb begin
    res_o = res_q;
    res_o.queue_empty = (count_q == '0);
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("task count exceeds table depth");

  a_head_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IdxW'(Depth - 1))
    else $error("head slot out of range");

  a_idc_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idc_q != '0)
    else $error("id counter reached zero");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && rd_en_o) |-> (wr_addr_o != rd_addr_o))
    else $error("read and write hit the same slot");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StDone) |-> !wr_en_o)
    else $error("table written outside an event");

endmodule

### rtl/round_robin_task_queue.sv
// Round-robin task queue, top level: stream ports, task table storage,
// event sequencer and the output beat register. Depends on rrtq_pkg,
// rrtq_mem and rrtq_seq.
//
// One input beat is one scheduler event and yields exactly one output beat.
// Events run one at a time against a single-port-read task table. Lookup
// walks the table one entry per cycle; exit walks and compacts the table in
// the same pass. The output register lets the next event be accepted while
// a result still waits on the master side.
module round_robin_task_queue #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [2:0] mode, [18:3] task_id, [40:19] process_id, [47:41] zero
  input  logic [rrtq_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [15:0] assigned_id, [37:16] target_pid, [38] found, [60:39] activate_pid,
  // [61] activate, [62] queue_empty, [63] queue_full
  output logic [rrtq_pkg::OutDataWidth-1:0]  m_axis_tdata_o
);
  import rrtq_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned EntW = ID_WIDTH + PidWidth;

  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [EntW-1:0] wr_data, rd_data;
  logic            res_valid, res_ready;
  rrtq_res_t       res;
  rrtq_res_t       out_q;
  logic            out_valid_q;

  rrtq_mem #(
    .Depth (TABLE_DEPTH),
    .Width (EntW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rrtq_seq #(
    .Depth   (TABLE_DEPTH),
    .IdWidth (ID_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_mode_i    (s_axis_tdata_i[2:0]),
    .in_task_id_i (s_axis_tdata_i[18:3]),
    .in_pid_i     (s_axis_tdata_i[40:19]),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
